// ===== rtl/core/sld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

   localparam int PIXEL_W      = 8;
   localparam int LINE_WIDTH_W = 12;
   localparam int SUM_W        = 10;
   localparam int ERR_W        = 7;
   localparam int HALF_W       = 7;
   localparam int QUARTER_W    = 6;

   typedef logic [PIXEL_W-1:0]             pixel_type;
   typedef logic [LINE_WIDTH_W-1:0]        line_width_type;
   typedef logic signed [SUM_W-1:0]        sum_type;
   typedef logic signed [ERR_W-1:0]        err_type;
   typedef logic signed [HALF_W-1:0]       half_type;
   typedef logic signed [QUARTER_W-1:0]    quarter_type;

   localparam line_width_type LINE_WIDTH_RESET = 12'd2048;
   localparam sum_type        THRESHOLD        = 10'sd128;
   localparam sum_type        WHITE_LEVEL      = 10'sd255;
   localparam pixel_type      PIXEL_WHITE      = 8'd255;
   localparam pixel_type      PIXEL_BLACK      = 8'd0;

endpackage

`default_nettype wire

// ===== rtl/core/sld_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/sierra_lite_dither_1bit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sierra Lite error diffusion to one bit per pixel.
// Grey pixels enter on the req_ channel in raster order; req_frame_start marks the
// first pixel of a frame. Each transaction yields one rsp_ transaction carrying 0 or
// 255 and a flag for the last pixel of its row. The row length comes from the
// line width register, written through csr_wr_en and csr_wr_data; the user must
// write it only while idle, which the block does not enforce. A pixel is registered
// into the compute stage, which uses the line store read issued when it was
// accepted, and then into the output register. One pixel per cycle is sustained
// while the receiver does not stall; the line store has one read and one write
// port, and the extra write at the end of a row goes into the free write slot of
// the following cycle. When the receiver stalls, the output register holds its
// result and only an empty compute stage still takes one more pixel. Reset empties
// the pipeline, sets the line width to 2048 and starts the first row of a frame,
// which takes no error from above, so the line store needs no clearing.
module sierra_lite_dither_1bit
   import sld_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [PIXEL_W-1:0]      req_pixel_in,
   input  wire logic                    req_frame_start,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [PIXEL_W-1:0]      rsp_pixel_out,
   output logic                         rsp_row_last,
   input  wire logic                    csr_wr_en,
   input  wire logic [LINE_WIDTH_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int XW = (CW > LINE_WIDTH_W) ? CW : LINE_WIDTH_W;

   line_width_type  line_width_ff;
   logic [AW-1:0]   column_count_ff, column_count_in;
   logic            in_first_row_ff, in_first_row_in;
   half_type        right_error_ff, right_error_in;
   quarter_type     pending_quarter_ff, pending_quarter_in;

   logic            s1_valid_ff, s1_valid_in;
   pixel_type       s1_pixel_ff;
   logic [AW-1:0]   s1_col_ff;
   logic            s1_last_ff;
   logic            s1_first_ff;
   logic            s1_start_ff;

   logic            byp_valid_ff, byp_valid_in;
   err_type         byp_data_ff, byp_data_in;

   logic            def_valid_ff, def_valid_in;
   logic [AW-1:0]   def_addr_ff;
   err_type         def_data_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   pixel_type       rsp_pixel_out_ff;
   logic            rsp_row_last_ff;

   logic            accept;
   logic            s1_adv;
   logic [XW-1:0]   width_raw;
   logic [XW-1:0]   width_eff;
   logic [AW-1:0]   col_new;
   logic [XW-1:0]   col_next_x;
   logic            last_new;
   logic            first_new;

   logic [ERR_W-1:0] rd_data;
   err_type         above_sel;
   err_type         above;
   half_type        right;
   sum_type         sum;
   logic            white;
   sum_type         err;
   sum_type         err_half;
   half_type        half;
   half_type        half_quarter;
   quarter_type     quarter;

   logic            cur_wr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   err_type         wr_data;

   // Input stage: column and row tracking depend only on the count, not on data.
   assign accept    = req_valid && req_ready;
   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_comb begin
      width_raw = XW'(line_width_ff);
      priority if (width_raw == '0) begin
         width_eff = XW'(1);
      end else if (width_raw > XW'(MAX_WIDTH)) begin
         width_eff = XW'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
   end

   assign col_new    = req_frame_start ? '0 : column_count_ff;
   assign col_next_x = XW'(col_new) + XW'(1);
   assign last_new   = col_next_x >= width_eff;
   assign first_new  = req_frame_start || in_first_row_ff;

   always_comb begin
      column_count_in = column_count_ff;
      in_first_row_in = in_first_row_ff;
      if (accept) begin
         column_count_in = last_new ? '0 : AW'(col_next_x);
         in_first_row_in = last_new ? 1'b0 : first_new;
      end
   end

   // Compute stage. The newest write to this column wins over the stored read.
   always_comb begin
      priority if (def_valid_ff && (def_addr_ff == s1_col_ff)) begin
         above_sel = def_data_ff;
      end else if (byp_valid_ff) begin
         above_sel = byp_data_ff;
      end else begin
         above_sel = err_type'(rd_data);
      end
   end

   assign above        = s1_first_ff ? '0 : above_sel;
   assign right        = s1_start_ff ? '0 : right_error_ff;
   assign sum          = sum_type'({2'b00, s1_pixel_ff}) + SUM_W'(right) + SUM_W'(above);
   assign white        = sum >= THRESHOLD;
   assign err          = white ? (sum - WHITE_LEVEL) : sum;
   assign err_half     = err >>> 1;
   assign half         = err_half[HALF_W-1:0];
   assign half_quarter = half >>> 1;
   assign quarter      = half_quarter[QUARTER_W-1:0];

   // The down-left quarter joins the pending one at col-1. The straight-down
   // quarter of a row's last pixel is written in the following cycle, when the next
   // pixel sits at column zero and leaves the write port free.
   assign cur_wr       = s1_adv && (s1_col_ff != '0);
   assign def_valid_in = s1_adv && s1_last_ff;

   always_comb begin
      wr_en = def_valid_ff || cur_wr;
      if (def_valid_ff) begin
         wr_addr = def_addr_ff;
         wr_data = def_data_ff;
      end else begin
         wr_addr = s1_col_ff - AW'(1);
         wr_data = ERR_W'(pending_quarter_ff) + ERR_W'(quarter);
      end
   end

   always_comb begin
      byp_valid_in = byp_valid_ff;
      byp_data_in  = byp_data_ff;
      if (accept) begin
         byp_valid_in = wr_en && (wr_addr == col_new);
         byp_data_in  = wr_data;
      end else if (wr_en && (wr_addr == s1_col_ff)) begin
         byp_valid_in = 1'b1;
         byp_data_in  = wr_data;
      end
   end

   always_comb begin
      right_error_in     = right_error_ff;
      pending_quarter_in = pending_quarter_ff;
      if (s1_adv) begin
         right_error_in     = s1_last_ff ? '0 : half;
         pending_quarter_in = s1_last_ff ? '0 : quarter;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff      <= LINE_WIDTH_RESET;
         column_count_ff    <= '0;
         in_first_row_ff    <= 1'b1;
         right_error_ff     <= '0;
         pending_quarter_ff <= '0;
         s1_valid_ff        <= 1'b0;
         byp_valid_ff       <= 1'b0;
         def_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            line_width_ff <= csr_wr_data;
         end
         column_count_ff    <= column_count_in;
         in_first_row_ff    <= in_first_row_in;
         right_error_ff     <= right_error_in;
         pending_quarter_ff <= pending_quarter_in;
         s1_valid_ff        <= s1_valid_in;
         byp_valid_ff       <= byp_valid_in;
         def_valid_ff       <= def_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= byp_data_in;
      if (accept) begin
         s1_pixel_ff <= req_pixel_in;
         s1_col_ff   <= col_new;
         s1_last_ff  <= last_new;
         s1_first_ff <= first_new;
         s1_start_ff <= req_frame_start;
      end
      if (def_valid_in) begin
         def_addr_ff <= s1_col_ff;
         def_data_ff <= ERR_W'(quarter);
      end
      if (s1_adv) begin
         rsp_pixel_out_ff <= white ? PIXEL_WHITE : PIXEL_BLACK;
         rsp_row_last_ff  <= s1_last_ff;
      end
   end

   sld_ram #(
      .WIDTH (ERR_W),
      .DEPTH (MAX_WIDTH)
   ) u_below_row (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (col_new),
      .rd_data (rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_out_ff;
   assign rsp_row_last  = rsp_row_last_ff;

`ifndef SYNTHESIS
   // The end-of-row write never collides with a down-left write.
   a_def_slot_free: assert property (@(posedge clock) disable iff (reset)
      def_valid_ff |-> !cur_wr)
      else $error("deferred line store write collides with a pixel write");

   // A held compute stage keeps its pixel and position.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_col_ff)
                                    && $stable(s1_last_ff) && $stable(s1_pixel_ff)))
      else $error("compute stage changed while stalled");

   // The compute stage only advances into a free or draining output register.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_row_last_ff)
                                        && (rsp_pixel_out_ff == PIXEL_WHITE
                                            || rsp_pixel_out_ff == PIXEL_BLACK)))
      else $error("output register overwritten or holds a grey level");
`endif

endmodule

`default_nettype wire

// ===== sim/sierra_lite_dither_1bit_tb.sv =====
`timescale 1ns / 1ps

module sierra_lite_dither_1bit_tb;
   import sld_pkg::*;

   localparam int MAX_W         = 2048;
   localparam int RANDOM_PIXELS = 680;
   localparam int WIDE_PIXELS   = 80;
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      pixel_type pixel;
      logic      row_last;
   } dithered_type;

   logic           clock           = 1'b0;
   logic           reset           = 1'b1;
   logic           req_valid       = 1'b0;
   logic           req_ready;
   pixel_type      req_pixel_in    = '0;
   logic           req_frame_start = 1'b0;
   logic           rsp_valid;
   logic           rsp_ready       = 1'b0;
   pixel_type      rsp_pixel_out;
   logic           rsp_row_last;
   logic           csr_wr_en       = 1'b0;
   line_width_type csr_wr_data     = '0;

   // Mirror of the block: error line for the next row and the carries along the row.
   int             err_line [MAX_W];
   int             run_col       = 0;
   int             carry_half    = 0;
   int             carry_quarter = 0;
   logic           top_row       = 1'b1;
   line_width_type width_reg     = LINE_WIDTH_RESET;

   dithered_type   expected_pixels [$];
   logic           calm          = 1'b0;
   int             mismatches    = 0;
   int             pixels_sent   = 0;
   int             random_pixels = 0;
   int             results_seen  = 0;
   int             rows_done     = 0;
   int             frames_started = 0;
   int             widths_used   = 0;

   sierra_lite_dither_1bit u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_row_last    (rsp_row_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding.", expected_pixels.size());
      $display("TEST FAILED");
      $finish;
   end

   function automatic dithered_type dither_pixel(input pixel_type pix, input logic fs);
      dithered_type res;
      int w, col, above, level, half, quarter;
      if (fs) begin
         run_col       = 0;
         carry_half    = 0;
         carry_quarter = 0;
         top_row       = 1'b1;
      end
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAX_W) w = MAX_W;
      col = run_col;
      if (col >= MAX_W) col = MAX_W - 1;
      above = top_row ? 0 : err_line[col];
      level = int'(pix) + carry_half + above;
      res.pixel = PIXEL_BLACK;
      if (level >= int'(THRESHOLD)) begin
         res.pixel = PIXEL_WHITE;
         level     = level - int'(WHITE_LEVEL);
      end
      half    = level >>> 1;
      quarter = half >>> 1;
      if (col > 0) err_line[col - 1] = carry_quarter + quarter;
      res.row_last = (col + 1 >= w);
      if (res.row_last) begin
         // The last pixel of a row keeps only its straight-down share.
         err_line[col] = quarter;
         run_col       = 0;
         carry_half    = 0;
         carry_quarter = 0;
         top_row       = 1'b0;
         rows_done++;
      end else begin
         carry_half    = half;
         carry_quarter = quarter;
         run_col       = col + 1;
      end
      return res;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type corner [4];
      corner = '{8'd0, 8'd255, 8'd127, 8'd128};
      if ($urandom_range(99) < 20) return corner[$urandom_range(3)];
      return pixel_type'($urandom_range(255));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 16);
   end

   always @(posedge clock) begin
      dithered_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                      results_seen));
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_pixel_out !== want.pixel)
               report_mismatch($sformatf("result %0d: pixel_out %0d, expected %0d",
                                         results_seen, rsp_pixel_out, want.pixel));
            if (rsp_row_last !== want.row_last)
               report_mismatch($sformatf("result %0d: row_last %0b, expected %0b",
                                         results_seen, rsp_row_last, want.row_last));
         end
         results_seen++;
      end
   end

   // Valid is lowered only during a gap or a drain, so back-to-back pixels keep it high.
   task automatic send_pixel(input pixel_type pix, input logic fs);
      while (!calm && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_in    <= pix;
      req_frame_start <= fs;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(dither_pixel(pix, fs));
      pixels_sent++;
      if (fs) frames_started++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_line_width(input line_width_type w);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      width_reg = w;
      widths_used++;
   endtask

   // Out of reset the block must behave as if a frame had just started.
   task automatic test_stream_before_frame();
      send_pixel(8'd127, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd128, 1'b0);
      wait_drained();
   endtask

   task automatic test_narrow_frame();
      set_line_width(12'd4);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd127, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd128, 1'b0);
      // Restart in the middle of a row drops every pending error.
      send_pixel(8'd200, 1'b1);
      send_pixel(8'd60, 1'b0);
      wait_drained();
   endtask

   task automatic test_single_column();
      set_line_width(12'd0);
      send_pixel(8'd200, 1'b1);
      send_pixel(8'd100, 1'b0);
      wait_drained();
      set_line_width(12'd1);
      send_pixel(8'd127, 1'b1);
      send_pixel(8'd128, 1'b0);
      wait_drained();
   endtask

   // An oversized width acts as the maximum; shrinking it mid-row ends that row.
   task automatic test_width_clamp_and_shrink();
      int i;
      set_line_width(12'd4095);
      send_pixel(8'd90, 1'b1);
      for (i = 0; i < 4; i++) send_pixel(random_pixel(), 1'b0);
      wait_drained();
      set_line_width(12'd3);
      for (i = 0; i < 4; i++) send_pixel(random_pixel(), 1'b0);
      wait_drained();
   endtask

   task automatic test_random_frames();
      int phase, rows, n, w, i;
      phase = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         if ($urandom_range(99) < 70) w = $urandom_range(1, 16);
         else w = $urandom_range(17, 64);
         // The stretch without idling gets wide rows so that it runs long.
         if (phase == 3) w = 64;
         set_line_width(line_width_type'(w));
         calm = (phase == 3);
         rows = (w <= 16) ? $urandom_range(2, 5) : 2;
         n = rows * w + $urandom_range(0, w - 1);
         for (i = 0; i < n; i++) begin
            // A rare stray frame start breaks the row structure.
            send_pixel(random_pixel(), (i == 0) || ($urandom_range(99) < 2));
            random_pixels++;
            if (phase == 2 && i == n / 2) wait_drained();
         end
         wait_drained();
         calm = 1'b0;
         phase++;
      end
   endtask

   task automatic test_widest_rows();
      int i;
      set_line_width(LINE_WIDTH_RESET);
      send_pixel(random_pixel(), 1'b1);
      for (i = 1; i < WIDE_PIXELS; i++) send_pixel(random_pixel(), 1'b0);
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_stream_before_frame();
      test_narrow_frame();
      test_single_column();
      test_width_clamp_and_shrink();
      test_random_frames();
      test_widest_rows();
      $display("Sent %0d pixels in %0d frames over %0d width settings.",
               pixels_sent, frames_started, widths_used);
      $display("Checked %0d results, %0d complete rows, %0d mismatches.",
               results_seen, rows_done, mismatches);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
